// ----- rtl/btb_pkg.sv -----
// ----------------------------------------------------------------------------
// btb_pkg
// shared codes and types of the branch target buffer
// ----------------------------------------------------------------------------
package btb_pkg;

	localparam int unsigned ALIGN_BITS  = 2;
	localparam int unsigned PC_W        = 32;
	localparam int unsigned COUNT_W     = 32;
	localparam int unsigned MODE_W      = 3;
	localparam int unsigned CFG_ADDR_W  = 2;

	// register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_POLICY = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_MODE   = 2'd1;

	// replacement policies
	localparam logic POLICY_LRU  = 1'b0;
	localparam logic POLICY_FIFO = 1'b1;

	// predictor modes
	localparam logic [MODE_W-1:0] MODE_TAKEN     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_NOT_TAKEN = 3'd1;
	localparam logic [MODE_W-1:0] MODE_BACKWARD  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ONE_BIT   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_TWO_BIT   = 3'd4;

	localparam logic [1:0] CTR_ALLOC_TAKEN     = 2'd2;
	localparam logic [1:0] CTR_ALLOC_NOT_TAKEN = 2'd1;
	localparam logic [1:0] CTR_MAX             = 2'd3;

	typedef struct packed {
		logic hit;
		logic pred;
	} btb_result_t;

endpackage

// ----- rtl/btb_ram.sv -----
// ----------------------------------------------------------------------------
// btb_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module btb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4,
	parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/btb_update.sv -----
// ----------------------------------------------------------------------------
// btb_update
// tag compare, prediction and row update for one set
// ----------------------------------------------------------------------------
module btb_update #(
	parameter int unsigned WAYS  = 4,
	parameter int unsigned TAG_W = 28,
	parameter int unsigned AGE_W = 2
) (
	input  logic [WAYS*(TAG_W+AGE_W+3)-1:0] row_in,
	input  logic [WAYS-1:0]                 valid_in,
	input  logic [TAG_W-1:0]                tag,
	input  logic                            backward,
	input  logic                            actual_taken,
	input  logic [btb_pkg::MODE_W-1:0]      mode,
	input  logic                            policy,
	output logic [WAYS*(TAG_W+AGE_W+3)-1:0] row_out,
	output logic [WAYS-1:0]                 valid_out,
	output btb_pkg::btb_result_t            result
);
	import btb_pkg::*;

	localparam int unsigned ENTRY_W = TAG_W + AGE_W + 3;
	localparam int unsigned WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
	// entry layout from bit 0: tag, age, last outcome, counter
	localparam int unsigned AGE_LO  = TAG_W;
	localparam int unsigned LAST_LO = TAG_W + AGE_W;
	localparam int unsigned CTR_LO  = TAG_W + AGE_W + 1;

	logic [TAG_W-1:0] tag_w  [WAYS];
	logic [AGE_W-1:0] age_w  [WAYS];
	logic             last_w [WAYS];
	logic [1:0]       ctr_w  [WAYS];

	logic             hit;
	logic [WAY_W-1:0] hit_way;
	logic             free_found;
	logic [WAY_W-1:0] free_way;
	logic [AGE_W-1:0] oldest;
	logic [WAY_W-1:0] old_way;
	logic [WAY_W-1:0] victim;
	logic             pred;
	logic [AGE_W-1:0] hit_age;
	logic [1:0]       hit_ctr;

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			tag_w[w]  = row_in[w*ENTRY_W +: TAG_W];
			age_w[w]  = row_in[w*ENTRY_W + AGE_LO +: AGE_W];
			last_w[w] = row_in[w*ENTRY_W + LAST_LO];
			ctr_w[w]  = row_in[w*ENTRY_W + CTR_LO +: 2];
		end
	end

	// first matching way, first free way, first strictly oldest way
	always_comb begin
		hit        = 1'b0;
		hit_way    = '0;
		free_found = 1'b0;
		free_way   = '0;
		oldest     = '0;
		old_way    = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (!hit && valid_in[w] && tag_w[w] == tag) begin
				hit     = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!free_found && !valid_in[w]) begin
				free_found = 1'b1;
				free_way   = WAY_W'(w);
			end
			if (age_w[w] > oldest) begin
				oldest  = age_w[w];
				old_way = WAY_W'(w);
			end
		end
	end

	assign victim  = free_found ? free_way : old_way;
	assign hit_age = age_w[hit_way];
	assign hit_ctr = ctr_w[hit_way];

	always_comb begin
		unique case (mode)
			MODE_TAKEN:     pred = 1'b1;
			MODE_NOT_TAKEN: pred = 1'b0;
			MODE_BACKWARD:  pred = backward;
			MODE_ONE_BIT:   pred = last_w[hit_way];
			default:        pred = hit_ctr[1];
		endcase
		if (!hit) begin
			pred = 1'b0;
		end
	end

	always_comb begin
		row_out   = row_in;
		valid_out = valid_in;
		for (int w = 0; w < WAYS; w++) begin
			if (hit) begin
				if (WAY_W'(w) == hit_way) begin
					row_out[w*ENTRY_W + LAST_LO] = actual_taken;
					if (actual_taken && hit_ctr != CTR_MAX) begin
						row_out[w*ENTRY_W + CTR_LO +: 2] = hit_ctr + 2'd1;
					end else if (!actual_taken && hit_ctr != 2'd0) begin
						row_out[w*ENTRY_W + CTR_LO +: 2] = hit_ctr - 2'd1;
					end
					if (policy == POLICY_LRU) begin
						row_out[w*ENTRY_W + AGE_LO +: AGE_W] = '0;
					end
				end else if (policy == POLICY_LRU && valid_in[w] && age_w[w] < hit_age) begin
					row_out[w*ENTRY_W + AGE_LO +: AGE_W] = age_w[w] + AGE_W'(1);
				end
			end else begin
				if (WAY_W'(w) == victim) begin
					valid_out[w] = 1'b1;
					row_out[w*ENTRY_W +: TAG_W]          = tag;
					row_out[w*ENTRY_W + AGE_LO +: AGE_W] = '0;
					row_out[w*ENTRY_W + LAST_LO]         = actual_taken;
					row_out[w*ENTRY_W + CTR_LO +: 2]     =
						actual_taken ? CTR_ALLOC_TAKEN : CTR_ALLOC_NOT_TAKEN;
				end else if (valid_in[w]) begin
					row_out[w*ENTRY_W + AGE_LO +: AGE_W] = age_w[w] + AGE_W'(1);
				end
			end
		end
	end

	assign result.hit  = hit;
	assign result.pred = pred;

endmodule

// ----- rtl/btb_branch_predictor.sv -----
// ----------------------------------------------------------------------------
// btb_branch_predictor
// set-associative branch target buffer with per-entry predictor
// ----------------------------------------------------------------------------
// One resolved branch is taken per request and answered with hit, prediction,
// correctness and four saturating totals. The set row is read from a
// registered-read ram at acceptance, then compared, updated and written back
// in the next cycle while the result is registered. Because of this
// read-modify-write of the set ram, the next branch is read only after the
// write, so back-to-back branches to one set see fresh data.
// Valid bits are flip-flops cleared by reset, so no clearing pass is needed.
module btb_branch_predictor #(
	parameter int unsigned SETS = 4,
	parameter int unsigned WAYS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [btb_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [btb_pkg::MODE_W-1:0]    cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// branch_pc[31:0], backward[32], actual_taken[33], zero pad
	input  logic [39:0]                   s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// btb_hit, prediction, prediction_correct, branch_total, hit_total,
	// miss_total, correct_total, zero pad
	output logic [135:0]                  m_tdata
);
	import btb_pkg::*;

	localparam int unsigned IDX_W   = $clog2(SETS + 1) - 1;
	localparam int unsigned ADDR_W  = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int unsigned TAG_W   = PC_W - ALIGN_BITS - IDX_W;
	localparam int unsigned AGE_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int unsigned ENTRY_W = TAG_W + AGE_W + 3;
	localparam int unsigned ROW_W   = WAYS * ENTRY_W;

	logic                policy_q;
	logic [MODE_W-1:0]   mode_q;

	logic                busy_s1;
	logic [ADDR_W-1:0]   set_s1;
	logic [TAG_W-1:0]    tag_s1;
	logic                back_s1;
	logic                taken_s1;

	logic [WAYS-1:0]     valid_q [SETS];

	logic [COUNT_W-1:0]  branch_q, hit_q, miss_q, correct_q;
	logic                hit_out_q, pred_out_q, corr_out_q;

	logic                accept;
	logic [PC_W-1:0]     pc;
	logic [ADDR_W-1:0]   set_in;
	logic [ROW_W-1:0]    row_rd, row_wr;
	logic [WAYS-1:0]     valid_wr;
	btb_result_t         res;
	logic                correct;

	assign s_tready = !busy_s1 && (!m_tvalid || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign pc       = s_tdata[PC_W-1:0];
	assign set_in   = ADDR_W'((pc >> ALIGN_BITS) & (SETS - 1));

	btb_ram #(
		.WIDTH (ROW_W),
		.DEPTH (SETS)
	) u_ram (
		.clk   (clk),
		.we    (busy_s1),
		.waddr (set_s1),
		.wdata (row_wr),
		.re    (accept),
		.raddr (set_in),
		.rdata (row_rd)
	);

	btb_update #(
		.WAYS  (WAYS),
		.TAG_W (TAG_W),
		.AGE_W (AGE_W)
	) u_update (
		.row_in       (row_rd),
		.valid_in     (valid_q[set_s1]),
		.tag          (tag_s1),
		.backward     (back_s1),
		.actual_taken (taken_s1),
		.mode         (mode_q),
		.policy       (policy_q),
		.row_out      (row_wr),
		.valid_out    (valid_wr),
		.result       (res)
	);

	assign correct = (res.pred == taken_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POLICY_LRU;
			mode_q   <= MODE_TWO_BIT;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_POLICY: policy_q <= cfg_wdata[0];
				REG_MODE:   mode_q   <= cfg_wdata;
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			set_s1   <= set_in;
			tag_s1   <= TAG_W'(pc >> (ALIGN_BITS + IDX_W));
			back_s1  <= s_tdata[32];
			taken_s1 <= s_tdata[33];
		end
		if (busy_s1) begin
			hit_out_q  <= res.hit;
			pred_out_q <= res.pred;
			corr_out_q <= correct;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1   <= 1'b0;
			m_tvalid  <= 1'b0;
			branch_q  <= '0;
			hit_q     <= '0;
			miss_q    <= '0;
			correct_q <= '0;
			for (int s = 0; s < SETS; s++) begin
				valid_q[s] <= '0;
			end
		end else begin
			busy_s1 <= accept;
			if (busy_s1) begin
				m_tvalid        <= 1'b1;
				valid_q[set_s1] <= valid_wr;
				if (~&branch_q) branch_q <= branch_q + 1'b1;
				if (res.hit && ~&hit_q) hit_q <= hit_q + 1'b1;
				if (!res.hit && ~&miss_q) miss_q <= miss_q + 1'b1;
				if (correct && ~&correct_q) correct_q <= correct_q + 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	assign m_tdata = {5'd0, correct_q, miss_q, hit_q, branch_q,
		corr_out_q, pred_out_q, hit_out_q};

	// a request is never taken while the previous one is being written back
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 |-> !s_tready)
		else $error("request accepted during write-back");

	// a new result only follows an accepted request
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(busy_s1))
		else $error("result without request");

	// hits, misses and correct predictions never exceed the branch count
	a_totals: assert property (@(posedge clk) disable iff (!arst_n)
		hit_q <= branch_q && miss_q <= branch_q && correct_q <= branch_q)
		else $error("totals inconsistent");

	// each branch bumps the branch total unless saturated
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 && ~&branch_q |=> branch_q == $past(branch_q) + 1'b1)
		else $error("branch total not advanced");

endmodule

// ----- verif/tb_btb_branch_predictor.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_btb_branch_predictor
// stimulus and checking for the branch target buffer
// ----------------------------------------------------------------------------
// Branches are sent over the input stream while a model of the sets, ages,
// histories and totals predicts each result; the output stream is compared
// field by field in order. Both policies and all predictor modes, including
// the undefined codes, are exercised with random backpressure on both sides.
module tb_btb_branch_predictor;
	import btb_pkg::*;

	localparam int SETS = 4;
	localparam int WAYS = 4;
	localparam int WDOG_LIMIT = 20000;

	typedef struct packed {
		logic [31:0] correct_total;
		logic [31:0] miss_total;
		logic [31:0] hit_total;
		logic [31:0] branch_total;
		logic        correct;
		logic        pred;
		logic        hit;
	} branch_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [MODE_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [39:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [135:0] m_tdata;

	btb_branch_predictor #(.SETS(SETS), .WAYS(WAYS)) u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the buffer
	logic        policy_q;
	logic [2:0]  mode_q;
	logic        sh_valid [SETS][WAYS];
	logic [27:0] sh_tag   [SETS][WAYS];
	int          sh_age   [SETS][WAYS];
	logic        sh_last  [SETS][WAYS];
	logic [1:0]  sh_ctr   [SETS][WAYS];
	logic [31:0] cnt_branch, cnt_hit, cnt_miss, cnt_correct;

	branch_res_t expected_q[$];
	int errors = 0;
	int wdog = 0;
	bit src_calm = 1'b0;
	bit sink_calm = 1'b0;
	bit sink_hold = 1'b0;

	function automatic logic [31:0] sat_inc(logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic branch_res_t predict_branch(logic [31:0] pc, logic bwd,
			logic tkn);
		branch_res_t r;
		int s, way, oldest, old_age;
		logic [27:0] tg;
		logic hit, pred;
		s = int'(pc[3:2]);
		tg = pc[31:4];
		hit = 1'b0;
		way = 0;
		pred = 1'b0;
		for (int w = 0; w < WAYS; w++)
			if (!hit && sh_valid[s][w] && sh_tag[s][w] == tg) begin
				hit = 1'b1;
				way = w;
			end
		cnt_branch = sat_inc(cnt_branch);
		if (hit) begin
			cnt_hit = sat_inc(cnt_hit);
			case (mode_q)
				MODE_TAKEN:     pred = 1'b1;
				MODE_NOT_TAKEN: pred = 1'b0;
				MODE_BACKWARD:  pred = bwd;
				MODE_ONE_BIT:   pred = sh_last[s][way];
				default:        pred = sh_ctr[s][way] >= 2'd2;
			endcase
			sh_last[s][way] = tkn;
			if (tkn && sh_ctr[s][way] < CTR_MAX) sh_ctr[s][way]++;
			if (!tkn && sh_ctr[s][way] > 2'd0) sh_ctr[s][way]--;
			if (policy_q == POLICY_LRU) begin
				old_age = sh_age[s][way];
				for (int w = 0; w < WAYS; w++)
					if (sh_valid[s][w] && sh_age[s][w] < old_age) sh_age[s][w]++;
				sh_age[s][way] = 0;
			end
		end else begin
			cnt_miss = sat_inc(cnt_miss);
			way = -1;
			for (int w = 0; w < WAYS; w++)
				if (way < 0 && !sh_valid[s][w]) way = w;
			if (way < 0) begin
				way = 0;
				oldest = 0;
				for (int w = 0; w < WAYS; w++)
					if (sh_age[s][w] > oldest) begin
						oldest = sh_age[s][w];
						way = w;
					end
			end
			for (int w = 0; w < WAYS; w++)
				if (sh_valid[s][w]) sh_age[s][w]++;
			sh_valid[s][way] = 1'b1;
			sh_tag[s][way] = tg;
			sh_age[s][way] = 0;
			sh_last[s][way] = tkn;
			sh_ctr[s][way] = tkn ? CTR_ALLOC_TAKEN : CTR_ALLOC_NOT_TAKEN;
		end
		if (pred == tkn) cnt_correct = sat_inc(cnt_correct);
		r.hit = hit;
		r.pred = pred;
		r.correct = (pred == tkn);
		r.branch_total = cnt_branch;
		r.hit_total = cnt_hit;
		r.miss_total = cnt_miss;
		r.correct_total = cnt_correct;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
		$display("mismatch %s: got %h expected %h", what, got, exp);
		errors++;
	endtask

	// valid stays high after the accept; whoever stops sending drops it
	task automatic send_branch(logic [31:0] pc, logic bwd, logic tkn);
		while (!src_calm && $urandom_range(99) < 10) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, tkn, bwd, pc};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_q.insert(expected_q.size(), predict_branch(pc, bwd, tkn));
	endtask

	task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [MODE_W-1:0] val);
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_POLICY) policy_q = val[0];
		else if (idx == REG_MODE) mode_q = val;
	endtask

	// pc mostly drawn from a small pool of tags so sets fill and evict
	function automatic logic [31:0] pick_pc();
		logic [31:0] pc;
		pc = $urandom;
		if ($urandom_range(9) < 8) pc[31:4] = 28'(($urandom_range(7) * 28'h0A5A5A5) ^
			(($urandom_range(1)) ? 28'hFFFFFFF : 28'h0));
		return pc;
	endfunction

	task automatic test_directed();
		send_branch(32'h0000_0000, 1'b0, 1'b0);
		send_branch(32'h0000_0000, 1'b1, 1'b1);
		send_branch(32'hFFFF_FFFF, 1'b1, 1'b1);
		send_branch(32'hFFFF_FFFF, 1'b0, 1'b0);
		// fill one set past its ways to force eviction of the oldest
		for (int i = 0; i < 6; i++) send_branch({28'(i + 1), 4'h8}, i[0], i[1]);
		send_branch({28'd1, 4'h8}, 1'b1, 1'b1);
		send_branch({28'd6, 4'h8}, 1'b0, 1'b1);
		send_branch({28'd6, 4'h8}, 1'b0, 1'b1);
		send_branch({28'd6, 4'h8}, 1'b0, 1'b1);
		send_branch({28'd6, 4'h8}, 1'b0, 1'b0);
	endtask

	task automatic test_modes();
		for (int p = 0; p < 2; p++)
			for (int m = 0; m < 8; m++) begin
				write_reg(REG_POLICY, MODE_W'(p));
				write_reg(REG_MODE, MODE_W'(m));
				for (int i = 0; i < 30; i++)
					send_branch(pick_pc(), 1'($urandom_range(1)), 1'($urandom_range(1)));
			end
	endtask

	task automatic test_random();
		write_reg(REG_POLICY, MODE_W'(POLICY_LRU));
		write_reg(REG_MODE, MODE_TWO_BIT);
		for (int i = 0; i < 480; i++) begin
			src_calm = (i >= 100 && i < 200);
			sink_calm = src_calm;
			send_branch(pick_pc(), 1'($urandom_range(1)), 1'($urandom_range(1)));
		end
		src_calm = 1'b0;
		sink_calm = 1'b0;
	endtask

	task automatic test_backpressure();
		sink_hold = 1'b1;
		src_calm = 1'b1;
		for (int i = 0; i < 20; i++)
			send_branch(pick_pc(), 1'($urandom_range(1)), 1'($urandom_range(1)));
		src_calm = 1'b0;
	endtask

	// receiver
	initial begin
		forever begin
			@(posedge clk);
			if (sink_hold) begin
				m_tready <= 1'b0;
				repeat (200) @(posedge clk);
				sink_hold = 1'b0;
			end
			m_tready <= sink_calm || ($urandom_range(99) >= 10);
		end
	end

	always @(posedge clk) begin
		branch_res_t got, exp;
		if (s_tvalid && s_tready || m_tvalid && m_tready) wdog <= 0;
		else wdog <= wdog + 1;
		if (m_tvalid && m_tready) begin
			got = branch_res_t'(m_tdata[130:0]);
			if (expected_q.size() == 0) begin
				$display("result with nothing expected");
				errors++;
			end else begin
				exp = expected_q.pop_front();
				if (got.hit !== exp.hit)
					report_mismatch("hit", 32'(got.hit), 32'(exp.hit));
				if (got.pred !== exp.pred)
					report_mismatch("pred", 32'(got.pred), 32'(exp.pred));
				if (got.correct !== exp.correct)
					report_mismatch("correct", 32'(got.correct), 32'(exp.correct));
				if (got.branch_total !== exp.branch_total)
					report_mismatch("branch_total", got.branch_total, exp.branch_total);
				if (got.hit_total !== exp.hit_total)
					report_mismatch("hit_total", got.hit_total, exp.hit_total);
				if (got.miss_total !== exp.miss_total)
					report_mismatch("miss_total", got.miss_total, exp.miss_total);
				if (got.correct_total !== exp.correct_total)
					report_mismatch("correct_total", got.correct_total, exp.correct_total);
			end
		end
	end

	initial begin
		wait (wdog >= WDOG_LIMIT);
		$display("btb_branch_predictor test failed");
		$finish;
	end

	initial begin
		policy_q = POLICY_LRU;
		mode_q = MODE_TWO_BIT;
		cnt_branch = '0;
		cnt_hit = '0;
		cnt_miss = '0;
		cnt_correct = '0;
		for (int s = 0; s < SETS; s++)
			for (int w = 0; w < WAYS; w++) begin
				sh_valid[s][w] = 1'b0;
				sh_tag[s][w] = '0;
				sh_age[s][w] = 0;
				sh_last[s][w] = 1'b0;
				sh_ctr[s][w] = '0;
			end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_modes();
		test_random();
		test_backpressure();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0) $display("btb_branch_predictor test passed");
		else $display("btb_branch_predictor test failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/btb_pkg.sv
rtl/btb_ram.sv
rtl/btb_update.sv
rtl/btb_branch_predictor.sv
verif/tb_btb_branch_predictor.sv
